// File: rtl/isort_pkg.sv
// Shared types and defaults for the insertion sorter.
// No dependencies; imported by every module of the block.
package isort_pkg;

  localparam int MAX_COUNT_DEF = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } isort_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } isort_out_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic               occ;
    logic               gt;
    logic signed [31:0] value;
  } isort_link_t;

endpackage

// File: rtl/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg for the neighbor link type.
module isort_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ins_en,
  input  logic                  shift_en,
  input  logic signed [31:0]    new_value,
  input  isort_pkg::isort_link_t left_link,
  input  isort_pkg::isort_link_t right_link,
  output isort_pkg::isort_link_t self_link
);
  import isort_pkg::*;

  logic               occ_r, occ_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               gt;

  // Strictly greater only, so equal values keep arrival order.
  assign gt = occ_r && (val_r > new_value);

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (shift_en) begin
      occ_nxt = right_link.occ;
      val_nxt = right_link.value;
    end else if (ins_en) begin
      if (left_link.gt) begin
        occ_nxt = 1'b1;
        val_nxt = left_link.value;
      end else if (left_link.occ && (gt || !occ_r)) begin
        occ_nxt = 1'b1;
        val_nxt = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign self_link.occ   = occ_r;
  assign self_link.gt    = gt;
  assign self_link.value = val_r;

endmodule

// File: rtl/insertion_sorter.sv
// Stable streaming insertion sorter: top level with the cell chain and drain control.
// Depends on isort_pkg and isort_cell.
//
// Usage: values arrive on the in_ channel (valid/ready), one per transaction.
// Each accepted value is inserted into a chain of MAX_COUNT cells,
// placed after any equal values already held. A transaction carrying
// last_item is inserted too, and the next cycle the chain starts draining:
// cell 0 drives the out_ channel directly and every accepted result shifts
// the chain left by one cell. The final result carries last_out. Values that
// arrive with the chain full are dropped and every result of that set
// carries overflow.
// Throughput: one value per cycle while filling; one result per cycle while
// draining when out_ready stays high. in_ready is low during the drain, so
// no new set is accepted until the final result of this set is taken.
// The first result is valid in the cycle after the last transaction.
// A stalled receiver holds the chain and the output unchanged.
// Reset (rst_n low, synchronous) empties the chain and clears the flags.
module insertion_sorter #(
  parameter int MAX_COUNT = isort_pkg::MAX_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  isort_pkg::isort_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output isort_pkg::isort_out_t out_data
);
  import isort_pkg::*;

  isort_link_t cell_q [MAX_COUNT];
  isort_link_t head_link;
  isort_link_t tail_link;

  logic draining_r, draining_nxt;
  logic overflow_r, overflow_nxt;
  logic in_acc, out_acc, full, ins_en, last_pop;

  assign head_link = '{occ: 1'b1, gt: 1'b0, value: '0};
  assign tail_link = '{occ: 1'b0, gt: 1'b0, value: '0};

  assign in_ready = !draining_r;
  assign in_acc   = in_valid && in_ready;
  assign full     = cell_q[MAX_COUNT-1].occ;
  assign ins_en   = in_acc && !full;

  assign out_valid = draining_r;
  assign out_acc   = out_valid && out_ready;
  assign last_pop  = out_acc && !cell_q[1].occ;

  assign out_data.sorted_value = cell_q[0].value;
  assign out_data.last_out     = !cell_q[1].occ;
  assign out_data.overflow     = overflow_r;

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    isort_link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = head_link;
    end else begin : g_mid_l
      assign left_l = cell_q[i-1];
    end
    if (i == MAX_COUNT - 1) begin : g_last
      assign right_l = tail_link;
    end else begin : g_mid_r
      assign right_l = cell_q[i+1];
    end
    isort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ins_en     (ins_en),
      .shift_en   (out_acc),
      .new_value  (in_data.value),
      .left_link  (left_l),
      .right_link (right_l),
      .self_link  (cell_q[i])
    );
  end

  always_comb begin
    draining_nxt = draining_r;
    overflow_nxt = overflow_r;
    if (in_acc && full) begin
      overflow_nxt = 1'b1;
    end
    if (in_acc && in_data.last_item) begin
      draining_nxt = 1'b1;
    end
    // drop the set flags once the final result is taken
    if (last_pop) begin
      draining_nxt = 1'b0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule
